// ===== hw/rtl/sha256_stream_hasher_top_assert.svh =====
// Assertion macros for the SHA-256 stream hasher checks.
// Used by the port-level checker; no other dependencies.
`ifndef SHA256_STREAM_HASHER_TOP_ASSERT_SVH
`define SHA256_STREAM_HASHER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SHA_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sha256 hasher check failed");

// next-cycle implication, sampled on clk, off during rst
`define SHA_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sha256 hasher check failed");

`endif

// ===== hw/rtl/sha256_pkg.sv =====
// Shared types and constants for the SHA-256 stream hasher.
// No dependencies; used by the round unit and the top level.
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;     // element 0 is H0 / a
  typedef logic [0:15][31:0] sched_t;   // element 0 is the current schedule word

  localparam hash_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

// ===== hw/rtl/sha256_stream_hasher_top.sv =====
// SHA-256 stream hasher top level: byte input stream, digest output stream.
// Depends on sha256_pkg and sha256_round.
//
// Input stream: one message byte per request. s_axis_tuser flags that
// s_axis_tdata carries a byte; s_axis_tlast ends the message (a request with
// tlast and no byte ends it too, so an empty message is allowed).
// Output stream: one request per message, the 256-bit digest, H0 in the
// low word.
// Bytes are taken one per cycle until 64 are held. The 64th byte starts a
// compression: 64 rounds of the shared round unit, one per cycle, then the
// chaining add, all with s_axis_tready low. On tlast the padding bytes are
// fed in one per cycle (up to 72) with one or two more compressions, then
// the digest is loaded into the output register.
// The output register holds the digest until taken; the next message may be
// streamed in meanwhile, and its finish waits for the register to empty.
// Reset (rst, synchronous) restores the initial hash values, clears the
// length and drops any digest not yet taken.
module sha256_stream_hasher_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tuser,  // [0] has_byte
  input  logic         s_axis_tlast,  // is_last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [255:0] m_axis_tdata   // digest_word0 .. digest_word7, 32 bits each
);
  import sha256_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FINAL = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]   state;
  logic [5:0]   fill;
  logic [60:0]  total;
  logic [511:0] sched;
  hash_t        work;
  hash_t        chain;
  hash_t        out_data;
  logic         out_valid;
  logic [5:0]   rnd;
  logic         pad_active;
  logic         pad_first;
  logic         len_done;
  logic         last_pend;

  logic         accept;
  logic         push_en;
  logic [7:0]   push_byte;
  logic [7:0]   pad_byte;
  logic [63:0]  len_bits;
  hash_t        work_next;
  word_t        w_new;

  sha256_round u_round (
    .work      (work),
    .sched     (sched_t'(sched)),
    .rnd       (rnd),
    .work_next (work_next),
    .w_new     (w_new)
  );

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_comb begin
    len_bits = {total, 3'b000};
    if (pad_first) begin
      pad_byte = PAD_MARK;
    end else if (len_done && fill[5:3] == 3'd7) begin
      pad_byte = len_bits[{~fill[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
    if (state == S_PAD) begin
      push_en   = 1'b1;
      push_byte = pad_byte;
    end else begin
      push_en   = accept && s_axis_tuser;
      push_byte = s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      total      <= '0;
      chain      <= H_INIT;
      out_valid  <= 1'b0;
      rnd        <= '0;
      pad_active <= 1'b0;
      pad_first  <= 1'b0;
      len_done   <= 1'b0;
      last_pend  <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      if (push_en) begin
        sched <= {sched[503:0], push_byte};
        fill  <= fill + 6'd1;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser) begin
              total <= total + 61'd1;
            end
            if (push_en && fill == 6'd63) begin
              state     <= S_ROUND;
              work      <= chain;
              rnd       <= '0;
              last_pend <= s_axis_tlast;
            end else if (s_axis_tlast) begin
              state      <= S_PAD;
              pad_active <= 1'b1;
              pad_first  <= 1'b1;
            end
          end
        end
        S_PAD: begin
          pad_first <= 1'b0;
          // marker past byte 55: the length goes into a second block
          if (pad_first) begin
            len_done <= (fill[5:3] != 3'd7);
          end
          if (fill == 6'd63) begin
            state <= S_ROUND;
            work  <= chain;
            rnd   <= '0;
          end
        end
        S_ROUND: begin
          work  <= work_next;
          sched <= {sched[479:0], w_new};
          rnd   <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (pad_active) begin
            if (len_done) begin
              state <= S_DONE;
            end else begin
              state    <= S_PAD;
              len_done <= 1'b1;
            end
          end else if (last_pend) begin
            state      <= S_PAD;
            pad_active <= 1'b1;
            pad_first  <= 1'b1;
            last_pend  <= 1'b0;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DONE: begin
          if (!out_valid || m_axis_tready) begin
            out_data   <= chain;
            out_valid  <= 1'b1;
            chain      <= H_INIT;
            total      <= '0;
            pad_active <= 1'b0;
            len_done   <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/sha256_round.sv =====
// One SHA-256 round plus the next message schedule word.
// Depends on sha256_pkg.
module sha256_round (
  input  sha256_pkg::hash_t  work,
  input  sha256_pkg::sched_t sched,
  input  logic [5:0]         rnd,
  output sha256_pkg::hash_t  work_next,
  output sha256_pkg::word_t  w_new
);
  import sha256_pkg::*;

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  word_t t1;
  word_t t2;
  word_t s0;
  word_t s1;
  word_t ch;
  word_t maj;
  word_t g0;
  word_t g1;

  always_comb begin
    s1  = rotr(work[4], 6) ^ rotr(work[4], 11) ^ rotr(work[4], 25);
    ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    s0  = rotr(work[0], 2) ^ rotr(work[0], 13) ^ rotr(work[0], 22);
    maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1  = work[7] + s1 + ch + round_k(rnd) + sched[0];
    t2  = s0 + maj;
    work_next[7] = work[6];
    work_next[6] = work[5];
    work_next[5] = work[4];
    work_next[4] = work[3] + t1;
    work_next[3] = work[2];
    work_next[2] = work[1];
    work_next[1] = work[0];
    work_next[0] = t1 + t2;
    g0 = rotr(sched[1], 7) ^ rotr(sched[1], 18) ^ (sched[1] >> 3);
    g1 = rotr(sched[14], 17) ^ rotr(sched[14], 19) ^ (sched[14] >> 10);
    w_new = sched[0] + g0 + sched[9] + g1;
  end

endmodule

// ===== hw/rtl/sha256_stream_hasher_chk.sv =====
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_top_assert.svh.
`include "sha256_stream_hasher_top_assert.svh"

module sha256_stream_hasher_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [7:0]   s_axis_tdata,
  input logic         s_axis_tuser,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [255:0] m_axis_tdata
);

  // stalled digest holds
  `SHA_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // no digest left over from before reset
  `SHA_ASSERT_IMP(a_rst_clear, $past(rst), !m_axis_tvalid)
  // the end of a message always costs at least a compression
  `SHA_ASSERT_NXT(a_last_busy, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  // a digest appears only while input is held off
  `SHA_ASSERT_IMP(a_out_when_busy, $rose(m_axis_tvalid), $past(!s_axis_tready))

endmodule

bind sha256_stream_hasher_top sha256_stream_hasher_chk u_chk (.*);
